/* hw/rtl/noc_pkg.sv */
// shared types, constants and character helpers for the natural order comparator
`timescale 1ns / 1ps
`default_nettype none

package noc_pkg;

	// width of the decimal number accumulators
	localparam int NUMBER_WIDTH = 32;

	// character codes that bound the classes
	localparam logic [7:0] CHAR_ZERO  = 8'd48;
	localparam logic [7:0] CHAR_NINE  = 8'd57;
	localparam logic [7:0] CHAR_UP_A  = 8'd65;
	localparam logic [7:0] CHAR_UP_Z  = 8'd90;
	localparam logic [7:0] CHAR_LOW_A = 8'd97;
	localparam logic [7:0] CHAR_LOW_Z = 8'd122;

	// verdict codes
	typedef enum logic [1:0] {
		ORD_LESS    = 2'd0,
		ORD_EQUAL   = 2'd1,
		ORD_GREATER = 2'd2
	} order_t;

	typedef logic [NUMBER_WIDTH-1:0] number_t;

	// comparison state carried from one item to the next
	typedef struct packed {
		logic    in_number;
		number_t value_a;
		number_t value_b;
		logic    decided;
		order_t  verdict;
	} state_t;

	localparam state_t STATE_RESET = '{
		in_number: 1'b0,
		value_a:   '0,
		value_b:   '0,
		decided:   1'b0,
		verdict:   ORD_EQUAL
	};

	function automatic logic is_letter(input logic [7:0] c);
		return ((c >= CHAR_UP_A) && (c <= CHAR_UP_Z)) ||
			((c >= CHAR_LOW_A) && (c <= CHAR_LOW_Z));
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
	endfunction

	// v * 10 + digit, held at all ones when it overflows
	function automatic number_t accumulate(input number_t v, input logic [7:0] c);
		logic [NUMBER_WIDTH+3:0] wide;
		logic [3:0]              digit;
		digit = 4'(c - CHAR_ZERO);
		wide  = ({4'b0, v} << 3) + ({4'b0, v} << 1) + {{NUMBER_WIDTH{1'b0}}, digit};
		if (|wide[NUMBER_WIDTH+3:NUMBER_WIDTH]) begin
			return '1;
		end
		return wide[NUMBER_WIDTH-1:0];
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/natural_order_compare.sv */
// natural order string comparator top level
//
// Compares two strings streamed one position per item, as a character pair with a
// presence flag per side. Letters compare by code, aligned digit runs compare as
// saturating decimal numbers, and the first difference fixes the verdict. The item
// flagged last produces one result, order (0 less, 1 equal, 2 greater), in the
// cycle after it is taken, and the block is then ready for the next pair of strings.
// One item is taken every cycle: the whole per-position update (classification,
// a times-ten add per side and one number compare) sits between the state
// registers and the result register. Items that are not last are taken even
// while a result waits; a last item waits only while the result register holds
// an unread, stalled result.
`timescale 1ns / 1ps
`default_nettype none

module natural_order_compare (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] char_a,
	input  logic [7:0] char_b,
	input  logic       has_a,
	input  logic       has_b,
	input  logic       last,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] order
);

	noc_pkg::state_t state_q;
	noc_pkg::state_t state_nxt;
	noc_pkg::order_t step_order;
	noc_pkg::order_t order_q;
	logic            out_valid_q;
	logic            in_accept;

	// a last item needs the result register free, or freeing this cycle
	assign in_stall  = out_valid_q && out_stall && last;
	assign in_accept = in_valid && !in_stall;

	noc_step u_step (
		.cur    (state_q),
		.char_a (char_a),
		.char_b (char_b),
		.has_a  (has_a),
		.has_b  (has_b),
		.last   (last),
		.nxt    (state_nxt),
		.order  (step_order)
	);

	// comparison state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= noc_pkg::STATE_RESET;
		end else if (in_accept) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_accept && last) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept && last) begin
			order_q <= step_order;
		end
	end

	assign out_valid = out_valid_q;
	assign order     = order_q;

	// a last item always yields a result next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		in_accept && last |=> out_valid)
		else $error("result missing after last item");

	// the state is back at reset after a last item
	assert property (@(posedge clk) disable iff (!arst_n)
		in_accept && last |=> !state_q.decided && !state_q.in_number)
		else $error("state not cleared after last item");

	// a frozen verdict does not move on later items
	assert property (@(posedge clk) disable iff (!arst_n)
		in_accept && !last && state_q.decided |=>
		state_q.decided && (state_q.verdict == $past(state_q.verdict)))
		else $error("frozen verdict changed");

	// no pending run means cleared accumulators
	assert property (@(posedge clk) disable iff (!arst_n)
		!state_q.in_number |-> (state_q.value_a == '0) && (state_q.value_b == '0))
		else $error("accumulators hold a value outside a digit run");

	// a stalled result is held
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(order))
		else $error("stalled result changed");

endmodule

`default_nettype wire

/* hw/rtl/noc_step.sv */
// next state and verdict for one character pair
`timescale 1ns / 1ps
`default_nettype none

module noc_step (
	input  noc_pkg::state_t cur,
	input  logic [7:0]      char_a,
	input  logic [7:0]      char_b,
	input  logic            has_a,
	input  logic            has_b,
	input  logic            last,
	output noc_pkg::state_t nxt,
	output noc_pkg::order_t order
);

	logic            letter_a;
	logic            letter_b;
	logic            digit_a;
	logic            digit_b;
	noc_pkg::number_t acc_a;
	noc_pkg::number_t acc_b;
	noc_pkg::state_t  st;

	// character classes
	assign letter_a = noc_pkg::is_letter(char_a);
	assign letter_b = noc_pkg::is_letter(char_b);
	assign digit_a  = noc_pkg::is_digit(char_a);
	assign digit_b  = noc_pkg::is_digit(char_b);

	// digit run accumulation, a new run starts from zero
	assign acc_a = noc_pkg::accumulate(cur.in_number ? cur.value_a : '0, char_a);
	assign acc_b = noc_pkg::accumulate(cur.in_number ? cur.value_b : '0, char_b);

	// position rules, then the end of string check
	always_comb begin
		st = cur;
		if (!st.decided) begin
			if (has_a && has_b) begin
				if (letter_a) begin
					if (letter_b) begin
						if (st.in_number) begin
							if (st.value_a > st.value_b) begin
								st.decided = 1'b1;
								st.verdict = noc_pkg::ORD_GREATER;
							end else if (st.value_a < st.value_b) begin
								st.decided = 1'b1;
								st.verdict = noc_pkg::ORD_LESS;
							end else begin
								st.in_number = 1'b0;
								st.value_a   = '0;
								st.value_b   = '0;
							end
						end
						if (!st.decided) begin
							if (char_a > char_b) begin
								st.decided = 1'b1;
								st.verdict = noc_pkg::ORD_GREATER;
							end else if (char_a < char_b) begin
								st.decided = 1'b1;
								st.verdict = noc_pkg::ORD_LESS;
							end
						end
					end else if (digit_b) begin
						st.decided = 1'b1;
						st.verdict = st.in_number ? noc_pkg::ORD_LESS : noc_pkg::ORD_GREATER;
					end else begin
						st.decided = 1'b1;
						st.verdict = (st.in_number && (st.value_b > st.value_a)) ?
							noc_pkg::ORD_LESS : noc_pkg::ORD_GREATER;
					end
				end else if (digit_a) begin
					if (!digit_b) begin
						st.decided = 1'b1;
						st.verdict = st.in_number ? noc_pkg::ORD_GREATER : noc_pkg::ORD_LESS;
					end else begin
						st.in_number = 1'b1;
						st.value_a   = acc_a;
						st.value_b   = acc_b;
					end
				end else begin
					if (!digit_b && st.in_number) begin
						if (st.value_a > st.value_b) begin
							st.decided = 1'b1;
							st.verdict = noc_pkg::ORD_GREATER;
						end else if (st.value_a < st.value_b) begin
							st.decided = 1'b1;
							st.verdict = noc_pkg::ORD_LESS;
						end else begin
							st.in_number = 1'b0;
							st.value_a   = '0;
							st.value_b   = '0;
						end
					end
					if (!st.decided && (letter_b || digit_b)) begin
						st.decided = 1'b1;
						st.verdict = noc_pkg::ORD_LESS;
					end
				end
				// last pair with both present: close the run as if both ended
				if (!st.decided && last) begin
					if (st.in_number) begin
						if (st.value_a > st.value_b) begin
							st.decided = 1'b1;
							st.verdict = noc_pkg::ORD_GREATER;
						end else if (st.value_a < st.value_b) begin
							st.decided = 1'b1;
							st.verdict = noc_pkg::ORD_LESS;
						end else begin
							st.in_number = 1'b0;
							st.value_a   = '0;
							st.value_b   = '0;
						end
					end
					if (!st.decided) begin
						st.decided = 1'b1;
						st.verdict = noc_pkg::ORD_EQUAL;
					end
				end
			end else begin
				// one or both strings have ended
				if (st.in_number) begin
					if (has_a && digit_a) begin
						st.decided = 1'b1;
						st.verdict = noc_pkg::ORD_GREATER;
					end else if (has_b && digit_b) begin
						st.decided = 1'b1;
						st.verdict = noc_pkg::ORD_LESS;
					end else if (st.value_a > st.value_b) begin
						st.decided = 1'b1;
						st.verdict = noc_pkg::ORD_GREATER;
					end else if (st.value_a < st.value_b) begin
						st.decided = 1'b1;
						st.verdict = noc_pkg::ORD_LESS;
					end else begin
						st.in_number = 1'b0;
						st.value_a   = '0;
						st.value_b   = '0;
					end
				end
				if (!st.decided) begin
					st.decided = 1'b1;
					st.verdict = noc_pkg::ORD_EQUAL;
				end
			end
		end
		order = st.verdict;
		nxt   = last ? noc_pkg::STATE_RESET : st;
	end

endmodule

`default_nettype wire

/* verif/natural_order_compare_tb.sv */
// self-checking testbench for the natural order string comparator
`timescale 1ns / 1ps
`default_nettype none

module natural_order_compare_tb;

	localparam int TARGET_ITEMS = 400;
	localparam int IDLE_LIMIT   = 2000;
	localparam int DRAIN_CYCLES = 8;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       in_stall;
	logic [7:0] char_a    = 8'd0;
	logic [7:0] char_b    = 8'd0;
	logic       has_a     = 1'b0;
	logic       has_b     = 1'b0;
	logic       last      = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [1:0] order;

	natural_order_compare u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.char_a    (char_a),
		.char_b    (char_b),
		.has_a     (has_a),
		.has_b     (has_b),
		.last      (last),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.order     (order)
	);

	// tracks the comparison of the string pair in flight and the verdicts owed
	class verdict_tracker;
		logic             run_open;
		noc_pkg::number_t num_a;
		noc_pkg::number_t num_b;
		logic             frozen;
		noc_pkg::order_t  verdict;
		noc_pkg::order_t  expected_verdicts[$];
		int               errors;
		int               checked;
		int               items_seen;

		function new();
			errors     = 0;
			checked    = 0;
			items_seen = 0;
			restart();
		endfunction

		function void restart();
			run_open = 1'b0;
			num_a    = '0;
			num_b    = '0;
			frozen   = 1'b0;
			verdict  = noc_pkg::ORD_EQUAL;
		endfunction

		function bit alpha(logic [7:0] c);
			return (c >= noc_pkg::CHAR_UP_A && c <= noc_pkg::CHAR_UP_Z) ||
				(c >= noc_pkg::CHAR_LOW_A && c <= noc_pkg::CHAR_LOW_Z);
		endfunction

		function bit numeral(logic [7:0] c);
			return c >= noc_pkg::CHAR_ZERO && c <= noc_pkg::CHAR_NINE;
		endfunction

		// decimal shift-in that sticks at all ones
		function noc_pkg::number_t shift_in_digit(noc_pkg::number_t v, logic [7:0] c);
			logic [noc_pkg::NUMBER_WIDTH+4:0] wide;
			noc_pkg::number_t                 top;
			top  = '1;
			wide = {5'b0, v} * 10 + (c - noc_pkg::CHAR_ZERO);
			if (wide > {5'b0, top}) begin
				return top;
			end
			return wide[noc_pkg::NUMBER_WIDTH-1:0];
		endfunction

		function void fix(noc_pkg::order_t v);
			frozen  = 1'b1;
			verdict = v;
		endfunction

		// pending numbers: a difference decides, a tie closes the run
		function void compare_numbers();
			if (num_a > num_b) begin
				fix(noc_pkg::ORD_GREATER);
			end else if (num_a < num_b) begin
				fix(noc_pkg::ORD_LESS);
			end else begin
				run_open = 1'b0;
				num_a    = '0;
				num_b    = '0;
			end
		endfunction

		// one position with both characters present
		function void judge_position(logic [7:0] a, logic [7:0] b);
			if (alpha(a)) begin
				if (alpha(b)) begin
					if (run_open) begin
						compare_numbers();
						if (frozen) begin
							return;
						end
					end
					if (a > b) begin
						fix(noc_pkg::ORD_GREATER);
					end else if (a < b) begin
						fix(noc_pkg::ORD_LESS);
					end
				end else if (numeral(b)) begin
					fix(run_open ? noc_pkg::ORD_LESS : noc_pkg::ORD_GREATER);
				end else begin
					fix((run_open && num_b > num_a) ? noc_pkg::ORD_LESS : noc_pkg::ORD_GREATER);
				end
			end else if (numeral(a)) begin
				if (!numeral(b)) begin
					fix(run_open ? noc_pkg::ORD_GREATER : noc_pkg::ORD_LESS);
				end else begin
					if (!run_open) begin
						run_open = 1'b1;
						num_a    = '0;
						num_b    = '0;
					end
					num_a = shift_in_digit(num_a, a);
					num_b = shift_in_digit(num_b, b);
				end
			end else begin
				if (!numeral(b) && run_open) begin
					compare_numbers();
					if (frozen) begin
						return;
					end
				end
				if (alpha(b) || numeral(b)) begin
					fix(noc_pkg::ORD_LESS);
				end
			end
		endfunction

		// end of either string: always freezes the verdict
		function void judge_end(logic pa, logic [7:0] a, logic pb, logic [7:0] b);
			if (run_open) begin
				if (pa && numeral(a)) begin
					fix(noc_pkg::ORD_GREATER);
					return;
				end
				if (pb && numeral(b)) begin
					fix(noc_pkg::ORD_LESS);
					return;
				end
				compare_numbers();
			end
			if (!frozen) begin
				fix(noc_pkg::ORD_EQUAL);
			end
		endfunction

		function void note_item(logic [7:0] a, logic [7:0] b, logic pa, logic pb, logic fin);
			items_seen++;
			if (!frozen) begin
				if (pa && pb) begin
					judge_position(a, b);
					if (!frozen && fin) begin
						judge_end(1'b0, 8'd0, 1'b0, 8'd0);
					end
				end else begin
					judge_end(pa, a, pb, b);
				end
			end
			if (fin) begin
				expected_verdicts.push_back(verdict);
				restart();
			end
		endfunction

		function void check_verdict(logic [1:0] got);
			noc_pkg::order_t want;
			if (expected_verdicts.size() == 0) begin
				$display("%0t: unexpected result, actual order %0d", $time, got);
				errors++;
				return;
			end
			want = expected_verdicts.pop_front();
			checked++;
			if (got !== want) begin
				$display("%0t: order mismatch, expected %0d, actual %0d", $time, want, got);
				errors++;
			end
		endfunction

		function int owed();
			return expected_verdicts.size();
		endfunction
	endclass

	verdict_tracker tracker = new();

	logic [7:0] text_a[$];
	logic [7:0] text_b[$];
	int         burst_left = 0;
	int         pairs_sent = 0;
	int         idle_cycles = 0;
	logic [6:0] phase_cnt = '0;
	logic [1:0] stall_mode = 2'd0;
	logic [3:0] hold_cnt = '0;

	// clock
	initial begin
		forever #10 clk = ~clk;
	end

	// monitor both channels
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				tracker.note_item(char_a, char_b, has_a, has_b, last);
			end
			if (out_valid && !out_stall) begin
				tracker.check_verdict(order);
			end
		end
	end

	// watchdog on cycles with no handshake at all
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == IDLE_LIMIT) begin
			$display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
			$display("status: fail");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// receiver stall pattern, mode picked anew each time the 7-bit phase counter wraps
	always @(posedge clk) begin
		phase_cnt <= phase_cnt + 1'b1;
		if (phase_cnt == '0) begin
			stall_mode <= 2'($urandom_range(0, 2));
		end
		case (stall_mode)
			2'd0: begin
				out_stall <= 1'b0;
			end
			2'd1: begin
				out_stall <= 1'($urandom_range(0, 1));
			end
			default: begin
				if (hold_cnt == '0) begin
					out_stall <= !out_stall;
					hold_cnt  <= out_stall ? 4'($urandom_range(0, 3)) : 4'($urandom_range(0, 7));
				end else begin
					hold_cnt <= hold_cnt - 1'b1;
				end
			end
		endcase
	end

	// present one item and hold it until taken
	task send_item(logic [7:0] a, logic [7:0] b, logic pa, logic pb, logic fin);
		in_valid <= 1'b1;
		char_a   <= a;
		char_b   <= b;
		has_a    <= pa;
		has_b    <= pb;
		last     <= fin;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
	endtask

	// sender bursts with random gaps, some stretches back to back
	task pace();
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				in_valid <= 1'b0;
				char_a   <= 8'($urandom_range(0, 255));
				char_b   <= 8'($urandom_range(0, 255));
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
	endtask

	// stream the two queued strings position by position
	task stream_pair();
		int n;
		logic pa;
		logic pb;
		logic [7:0] ca;
		logic [7:0] cb;
		n = (text_a.size() > text_b.size()) ? text_a.size() : text_b.size();
		if (n == 0) begin
			n = 1;
		end
		for (int i = 0; i < n; i++) begin
			pa = i < text_a.size();
			pb = i < text_b.size();
			ca = pa ? text_a[i] : 8'($urandom_range(0, 255));
			cb = pb ? text_b[i] : 8'($urandom_range(0, 255));
			pace();
			send_item(ca, cb, pa, pb, i == n - 1);
		end
		pairs_sent++;
	endtask

	task run_text(string sa, string sb);
		text_a.delete();
		text_b.delete();
		for (int i = 0; i < sa.len(); i++) begin
			text_a.push_back(sa[i]);
		end
		for (int i = 0; i < sb.len(); i++) begin
			text_b.push_back(sb[i]);
		end
		stream_pair();
	endtask

	function logic [7:0] pick_char(int cls);
		logic [7:0] c;
		if (cls == 0) begin
			c = $urandom_range(0, 1) ?
				8'($urandom_range(noc_pkg::CHAR_UP_A, noc_pkg::CHAR_UP_Z)) :
				8'($urandom_range(noc_pkg::CHAR_LOW_A, noc_pkg::CHAR_LOW_Z));
		end else if (cls == 1) begin
			c = 8'($urandom_range(noc_pkg::CHAR_ZERO, noc_pkg::CHAR_NINE));
		end else begin
			c = 8'($urandom_range(0, 255));
			while (tracker.alpha(c) || tracker.numeral(c)) begin
				c = 8'($urandom_range(0, 255));
			end
		end
		return c;
	endfunction

	// letter, digit run or other character appended to a string
	task add_token(inout logic [7:0] q[$]);
		int cls;
		int len;
		cls = $urandom_range(0, 2);
		if (cls == 1) begin
			len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 4);
		end else begin
			len = 1;
		end
		repeat (len) q.push_back(pick_char(cls));
	endtask

	// second string copied from the first, then at most one random change to either
	task make_related_pair();
		int k;
		text_a.delete();
		repeat ($urandom_range(1, 5)) add_token(text_a);
		text_b = text_a;
		case ($urandom_range(0, 4))
			0: ;
			1: begin
				k = $urandom_range(0, text_b.size() - 1);
				text_b[k] = pick_char($urandom_range(0, 2));
			end
			2: begin
				k = $urandom_range(0, text_b.size());
				while (text_b.size() > k) void'(text_b.pop_back());
			end
			3: add_token(text_b);
			default: begin
				k = $urandom_range(0, text_a.size());
				while (text_a.size() > k) void'(text_a.pop_back());
			end
		endcase
	endtask

	task make_random_pair();
		text_a.delete();
		text_b.delete();
		repeat ($urandom_range(0, 6)) text_a.push_back(8'($urandom_range(0, 255)));
		repeat ($urandom_range(0, 6)) text_b.push_back(8'($urandom_range(0, 255)));
	endtask

	// unstructured items with random flags, closed by a last item
	task send_noise();
		int n;
		n = $urandom_range(1, 6);
		for (int i = 0; i < n; i++) begin
			pace();
			send_item(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
				1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
				(i == n - 1) || ($urandom_range(0, 3) == 0));
		end
	endtask

	initial begin
		int pick;

		// reset
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed cases
		run_text("a", "b");
		run_text("b", "a");
		run_text("9", "10");
		run_text("x", "x");
		run_text("a", "1");
		run_text("1", "-");
		run_text("-", "a");
		run_text("-", "1");
		run_text("#", "!");
		run_text("12a", "12b");
		run_text("5x", "5-");
		run_text("", "");
		run_text("4294967296", "4294967295");
		text_a = '{8'h00};
		text_b = '{8'hFF};
		stream_pair();
		text_a = '{8'hFF};
		text_b = '{8'h7A};
		stream_pair();

		// random part, mostly strings that share structure
		while (tracker.items_seen < TARGET_ITEMS) begin
			pick = $urandom_range(0, 9);
			if (pick < 7) begin
				make_related_pair();
				stream_pair();
			end else if (pick < 9) begin
				make_random_pair();
				stream_pair();
			end else begin
				send_noise();
			end
		end
		in_valid <= 1'b0;

		// drain
		while (tracker.owed() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d string pairs plus noise, %0d items sent, %0d verdicts checked",
			pairs_sent, tracker.items_seen, tracker.checked);
		$display("receiver stall modes and sender gaps varied throughout, %0d errors", tracker.errors);
		if (tracker.errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

`default_nettype wire
